// ----- design/hsru_pkg.sv -----
`default_nettype none
package hsru_pkg;

	localparam int TABLE_ENTRIES_DEF = 1024;

	localparam int HASH_W     = 64;
	localparam int KEY_W      = 25;
	localparam int VAL_W      = 6;
	localparam int CNT_W      = 11;
	localparam int P_W        = 5;
	localparam int Q_W        = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int TZ_W       = 7;
	localparam int RUN_W      = 7;
	localparam int TZ_STEP    = 8;
	localparam int ENC_W      = 32;
	localparam int ENC_SIGN_BIT = 31;

	localparam logic [CFG_IDX_W-1:0] REG_PRECISION        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPARSE_PRECISION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_BITS         = 2'd2;

	localparam logic [P_W-1:0] PRECISION_RST        = 5'd14;
	localparam logic [P_W-1:0] SPARSE_PRECISION_RST = 5'd25;
	localparam logic [Q_W-1:0] RUN_BITS_RST         = 3'd6;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_MERGE = 1'b1;

	localparam logic [VAL_W-1:0] VAL_MAX = 6'd63;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} tbl_req_t;

	typedef struct packed {
		logic updated;
		logic status;
	} tbl_resp_t;

	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	typedef enum logic [1:0] {
		TB_CLEAR,
		TB_IDLE,
		TB_PROBE
	} tbl_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TZ,
		ST_REQ,
		ST_WAIT,
		ST_HOLD
	} ctl_state_t;

	// trailing zero count of a nonzero byte
	function automatic logic [2:0] tz8(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd7;
		for (int i = 7; i >= 0; i--) begin
			if (b[i]) n = 3'(i);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- design/hsru_if.sv -----
`default_nettype none
interface hsru_item_if;
	logic                             valid;
	logic                             ready;
	logic                             operation;
	logic [hsru_pkg::HASH_W-1:0]      hash_value;
	logic [hsru_pkg::KEY_W-1:0]       entry_key;
	logic [hsru_pkg::VAL_W-1:0]       entry_value;

	modport source (output valid, operation, hash_value, entry_key, entry_value, input ready);
	modport sink (input valid, operation, hash_value, entry_key, entry_value, output ready);
endinterface

interface hsru_result_if;
	logic                        valid;
	logic                        ready;
	logic                        updated;
	logic [hsru_pkg::CNT_W-1:0]  entry_count;
	logic                        status;

	modport source (output valid, updated, entry_count, status, input ready);
	modport sink (input valid, updated, entry_count, status, output ready);
endinterface

interface hsru_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [hsru_pkg::CFG_IDX_W-1:0]  index;
	logic [hsru_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/hsru_tz.sv -----
`default_nettype none
module hsru_tz (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [hsru_pkg::HASH_W-1:0]       operand,
	output logic                                   done,
	output logic [hsru_pkg::TZ_W-1:0]              count
);

	localparam logic [hsru_pkg::TZ_W-1:0] LAST_CNT =
		hsru_pkg::TZ_W'(hsru_pkg::HASH_W - hsru_pkg::TZ_STEP);

	logic [hsru_pkg::HASH_W-1:0]  opnd_q;
	logic [hsru_pkg::TZ_W-1:0]    cnt_q;
	logic [hsru_pkg::TZ_W-1:0]    res_q;
	logic                         busy_q;
	logic                         done_q;
	logic [hsru_pkg::TZ_STEP-1:0] low_byte;
	logic                         finish;

	assign low_byte = opnd_q[hsru_pkg::TZ_STEP-1:0];
	assign finish   = busy_q && ((low_byte != '0) || (cnt_q == LAST_CNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
			if (start) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	// one byte per cycle; an all-zero word counts as the full width
	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= operand;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (low_byte != '0) begin
				res_q <= cnt_q + hsru_pkg::TZ_W'(hsru_pkg::tz8(low_byte));
			end else if (cnt_q == LAST_CNT) begin
				res_q <= hsru_pkg::TZ_W'(hsru_pkg::HASH_W);
			end
			opnd_q <= opnd_q >> hsru_pkg::TZ_STEP;
			cnt_q  <= cnt_q + hsru_pkg::TZ_W'(hsru_pkg::TZ_STEP);
		end
	end

	assign done  = done_q;
	assign count = res_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("tz unit started while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_q <= hsru_pkg::TZ_W'(hsru_pkg::HASH_W)))
		else $error("tz count out of range");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("tz unit done while still busy");

endmodule
`default_nettype wire

// ----- design/hsru_table.sv -----
`default_nettype none
module hsru_table #(
	parameter int TABLE_ENTRIES = hsru_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 req_valid,
	input  wire hsru_pkg::tbl_req_t                   req,
	output logic                                      ready,
	output logic                                      resp_valid,
	output hsru_pkg::tbl_resp_t                       resp,
	output logic [$clog2(TABLE_ENTRIES+1)-1:0]        count
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);
	localparam logic [AW:0]   ENTRIES_X = (AW+1)'(TABLE_ENTRIES);
	localparam logic [CW-1:0] FULL_CNT  = CW'(TABLE_ENTRIES);

	hsru_pkg::slot_t mem [TABLE_ENTRIES];
	hsru_pkg::slot_t rd_q;

	hsru_pkg::tbl_state_t state_q, state_d;

	logic [AW-1:0]                  addr_q;
	logic [AW-1:0]                  probe_q;
	logic [AW-1:0]                  clr_q;
	logic [CW-1:0]                  count_q;
	logic [hsru_pkg::KEY_W-1:0]     key_q;
	logic [hsru_pkg::VAL_W-1:0]     val_q;

	logic [AW-1:0]   fold;
	logic [AW-1:0]   home;
	logic [AW-1:0]   next_addr;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic            wr_en;
	hsru_pkg::slot_t wr_data;
	logic            cont;
	logic            ins;

	// home slot: fold the key down to the index width, then wrap once
	always_comb begin
		fold = '0;
		for (int i = 0; i < hsru_pkg::KEY_W; i++) begin
			fold[i % AW] = fold[i % AW] ^ req.key[i];
		end
		if ({1'b0, fold} >= ENTRIES_X) begin
			home = fold - AW'(TABLE_ENTRIES);
		end else begin
			home = fold;
		end
	end

	assign next_addr = (addr_q == LAST_SLOT) ? '0 : addr_q + AW'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			hsru_pkg::TB_CLEAR: begin
				if (clr_q == LAST_SLOT) state_d = hsru_pkg::TB_IDLE;
			end
			hsru_pkg::TB_IDLE: begin
				if (req_valid) state_d = hsru_pkg::TB_PROBE;
			end
			hsru_pkg::TB_PROBE: begin
				if (!cont) state_d = hsru_pkg::TB_IDLE;
			end
			default: state_d = hsru_pkg::TB_IDLE;
		endcase
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = addr_q;
		wr_data    = '0;
		rd_addr    = addr_q;
		resp_valid = 1'b0;
		resp       = '0;
		cont       = 1'b0;
		ins        = 1'b0;
		case (state_q)
			hsru_pkg::TB_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			hsru_pkg::TB_IDLE: begin
				rd_addr = home;
			end
			hsru_pkg::TB_PROBE: begin
				if (!rd_q.vld) begin
					// empty slot: the key is new
					wr_en        = 1'b1;
					wr_data      = '{vld: 1'b1, key: key_q, value: val_q};
					resp_valid   = 1'b1;
					resp.updated = 1'b1;
					ins          = 1'b1;
				end else if (rd_q.key == key_q) begin
					resp_valid = 1'b1;
					if (val_q > rd_q.value) begin
						wr_en        = 1'b1;
						wr_data      = '{vld: 1'b1, key: key_q, value: val_q};
						resp.updated = 1'b1;
					end
				end else if (probe_q == LAST_SLOT) begin
					// every slot taken by another key: drop
					resp_valid  = 1'b1;
					resp.status = 1'b1;
				end else begin
					cont    = 1'b1;
					rd_addr = next_addr;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsru_pkg::TB_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == hsru_pkg::TB_CLEAR) clr_q <= clr_q + AW'(1);
			if (ins) count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hsru_pkg::TB_IDLE && req_valid) begin
			addr_q  <= home;
			probe_q <= '0;
			key_q   <= req.key;
			val_q   <= req.value;
		end else if (cont) begin
			addr_q  <= next_addr;
			probe_q <= probe_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign ready = (state_q == hsru_pkg::TB_IDLE);
	assign count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above table size");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(resp_valid && resp.status) |-> (count_q == FULL_CNT))
		else $error("key dropped while table not full");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not advance entry count");

endmodule
`default_nettype wire

// ----- design/hll_sparse_register_update_unit.sv -----
`default_nettype none
// channel   dir  handshake       word
// cfg       in   valid/ready     index, data (precision, sparse_precision, run_bits)
// items     in   valid/ready     operation, hash_value, entry_key, entry_value
// results   out  valid/ready     updated, entry_count, status
//
// A merge word goes from accept through ST_REQ, ST_WAIT and ST_HOLD; a hash word passes
// through ST_TZ first, where the zero count scans a byte per cycle. The table probes one slot
// after another, up to TABLE_ENTRIES probes when full. The next word can be taken from the
// cycle the result shows. After reset a clearing pass writes every slot, with items not ready;
// cfg writes are taken throughout. A stalled result holds in the output register; the
// next word is accepted meanwhile and waits in the final stage until it frees.
module hll_sparse_register_update_unit #(
	parameter int TABLE_ENTRIES = hsru_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	hsru_cfg_if.sink       cfg,
	hsru_item_if.sink      items,
	hsru_result_if.source  results
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	hsru_pkg::ctl_state_t state_q, state_d;

	logic [hsru_pkg::P_W-1:0] prec_q;
	logic [hsru_pkg::P_W-1:0] sprec_q;
	logic [hsru_pkg::Q_W-1:0] runb_q;

	logic [hsru_pkg::KEY_W-1:0] key_q;
	logic [hsru_pkg::VAL_W-1:0] val_q;
	logic                       zero_mid_q;
	hsru_pkg::tbl_resp_t        resp_q;

	logic                       out_valid_q;
	logic                       upd_q;
	logic                       status_q;
	logic [hsru_pkg::CNT_W-1:0] cnt_out_q;

	logic take;
	logic tz_start;
	logic tz_done;
	logic out_load;
	logic tbl_req_valid;
	logic tbl_ready;
	logic tbl_resp_valid;

	hsru_pkg::tbl_req_t  tbl_req;
	hsru_pkg::tbl_resp_t tbl_resp;
	logic [CW-1:0]       tbl_count;
	logic [CW+hsru_pkg::CNT_W-1:0] cnt_ext;

	logic [hsru_pkg::ENC_W-1:0]  pmask;
	logic [hsru_pkg::ENC_W-1:0]  lowmask;
	logic [hsru_pkg::ENC_W-1:0]  mid;
	logic                        zero_mid;
	logic [hsru_pkg::HASH_W-1:0] hm;
	logic [hsru_pkg::HASH_W-1:0] tz_operand;
	logic [hsru_pkg::KEY_W-1:0]  hash_key;

	logic [hsru_pkg::TZ_W-1:0]  tz_count;
	logic [hsru_pkg::RUN_W-1:0] ntr;
	logic [hsru_pkg::RUN_W-1:0] field;
	logic [hsru_pkg::RUN_W:0]   qmask;
	logic [hsru_pkg::RUN_W-1:0] run_raw;
	logic [hsru_pkg::VAL_W-1:0] run_val;
	logic [hsru_pkg::P_W:0]     pos;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q  <= hsru_pkg::PRECISION_RST;
			sprec_q <= hsru_pkg::SPARSE_PRECISION_RST;
			runb_q  <= hsru_pkg::RUN_BITS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				hsru_pkg::REG_PRECISION:        prec_q  <= cfg.data[hsru_pkg::P_W-1:0];
				hsru_pkg::REG_SPARSE_PRECISION: sprec_q <= cfg.data[hsru_pkg::P_W-1:0];
				hsru_pkg::REG_RUN_BITS:         runb_q  <= cfg.data[hsru_pkg::Q_W-1:0];
				default: ;
			endcase
		end
	end

	// sparse encoding front end, from the word being accepted
	always_comb begin
		pmask    = (hsru_pkg::ENC_W'(1) << sprec_q) - hsru_pkg::ENC_W'(1);
		lowmask  = (hsru_pkg::ENC_W'(1) << prec_q) - hsru_pkg::ENC_W'(1);
		mid      = pmask ^ lowmask;
		zero_mid = (items.hash_value[hsru_pkg::ENC_W-1:0] & mid) == '0;
		if (zero_mid) begin
			hm = items.hash_value;
		end else begin
			hm = {{(hsru_pkg::HASH_W-hsru_pkg::ENC_SIGN_BIT){1'b0}},
				items.hash_value[hsru_pkg::ENC_SIGN_BIT-1:0]};
		end
		// clearing the bits below p makes tz(hm >> p) = tz(operand) - p
		tz_operand = hm & ~{{(hsru_pkg::HASH_W-hsru_pkg::ENC_W){1'b0}}, lowmask};
		hash_key   = items.hash_value[hsru_pkg::KEY_W-1:0] & pmask[hsru_pkg::KEY_W-1:0];
	end

	// run length from the zero count
	always_comb begin
		if (tz_count == hsru_pkg::TZ_W'(hsru_pkg::HASH_W)) begin
			ntr = hsru_pkg::RUN_W'(hsru_pkg::HASH_W + 1);
		end else begin
			ntr = tz_count - hsru_pkg::TZ_W'(prec_q) + hsru_pkg::TZ_W'(1);
		end
		// wide form: bits at or above the sign bit read back as ones
		for (int k = 0; k < hsru_pkg::RUN_W; k++) begin
			pos = {1'b0, sprec_q} + (hsru_pkg::P_W+1)'(k);
			field[k] = (pos >= (hsru_pkg::P_W+1)'(hsru_pkg::ENC_SIGN_BIT)) ? 1'b1 : ntr[k];
		end
		qmask = ((hsru_pkg::RUN_W+1)'(1) << runb_q) - (hsru_pkg::RUN_W+1)'(1);
		if (zero_mid_q) begin
			run_raw = field & qmask[hsru_pkg::RUN_W-1:0];
		end else begin
			run_raw = ntr;
		end
		if (run_raw > hsru_pkg::RUN_W'(hsru_pkg::VAL_MAX)) begin
			run_val = hsru_pkg::VAL_MAX;
		end else begin
			run_val = run_raw[hsru_pkg::VAL_W-1:0];
		end
	end

	assign take = items.valid && items.ready;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			hsru_pkg::ST_IDLE: begin
				if (take) begin
					if (items.operation == hsru_pkg::OP_MERGE) state_d = hsru_pkg::ST_REQ;
					else state_d = hsru_pkg::ST_TZ;
				end
			end
			hsru_pkg::ST_TZ: begin
				if (tz_done) state_d = hsru_pkg::ST_REQ;
			end
			hsru_pkg::ST_REQ: state_d = hsru_pkg::ST_WAIT;
			hsru_pkg::ST_WAIT: begin
				if (tbl_resp_valid) state_d = hsru_pkg::ST_HOLD;
			end
			hsru_pkg::ST_HOLD: begin
				if (!out_valid_q || results.ready) state_d = hsru_pkg::ST_IDLE;
			end
			default: state_d = hsru_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		items.ready   = (state_q == hsru_pkg::ST_IDLE) && tbl_ready;
		tz_start      = take && (items.operation == hsru_pkg::OP_ADD);
		tbl_req_valid = (state_q == hsru_pkg::ST_REQ);
		out_load      = (state_q == hsru_pkg::ST_HOLD) && (!out_valid_q || results.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hsru_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
		end
	end

	assign cnt_ext = {{hsru_pkg::CNT_W{1'b0}}, tbl_count};

	always_ff @(posedge clk) begin
		if (take) begin
			zero_mid_q <= zero_mid;
			val_q      <= items.entry_value;
			if (items.operation == hsru_pkg::OP_MERGE) key_q <= items.entry_key;
			else key_q <= hash_key;
		end else if (state_q == hsru_pkg::ST_TZ && tz_done) begin
			val_q <= run_val;
		end
		if (tbl_resp_valid) resp_q <= tbl_resp;
		if (out_load) begin
			upd_q     <= resp_q.updated;
			status_q  <= resp_q.status;
			cnt_out_q <= cnt_ext[hsru_pkg::CNT_W-1:0];
		end
	end

	assign tbl_req = '{key: key_q, value: val_q};

	hsru_tz u_tz (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (tz_start),
		.operand (tz_operand),
		.done    (tz_done),
		.count   (tz_count)
	);

	hsru_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (tbl_req_valid),
		.req        (tbl_req),
		.ready      (tbl_ready),
		.resp_valid (tbl_resp_valid),
		.resp       (tbl_resp),
		.count      (tbl_count)
	);

	assign results.valid       = out_valid_q;
	assign results.updated     = upd_q;
	assign results.status      = status_q;
	assign results.entry_count = cnt_out_q;

	a_resp_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_resp_valid |-> (state_q == hsru_pkg::ST_WAIT))
		else $error("table response outside wait state");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || results.ready))
		else $error("result overwritten before taken");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> (out_valid_q && $stable(upd_q)
			&& $stable(status_q) && $stable(cnt_out_q)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import hsru_pkg::*;

	localparam int TABLE_SLOTS = TABLE_ENTRIES_DEF;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int unsigned HOLD_OFF_CYCLES = 600;

	typedef struct packed {
		logic             operation;
		logic [HASH_W-1:0] hash;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} sketch_word_t;

	typedef struct packed {
		logic             updated;
		logic [CNT_W-1:0] entry_count;
		logic             status;
	} update_report_t;

	logic clk = 1'b0;
	logic arst_n;

	hsru_cfg_if    cfg_bus ();
	hsru_item_if   item_bus ();
	hsru_result_if result_bus ();

	hll_sparse_register_update_unit #(
		.TABLE_ENTRIES(TABLE_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.items(item_bus),
		.results(result_bus)
	);

	always #1 clk = ~clk;

	// predictor state: register copies and the sparse key -> max run table
	logic [P_W-1:0]   cur_precision = PRECISION_RST;
	logic [P_W-1:0]   cur_sparse    = SPARSE_PRECISION_RST;
	logic [Q_W-1:0]   cur_run_bits  = RUN_BITS_RST;
	logic [VAL_W-1:0] sparse_table [logic [KEY_W-1:0]];

	sketch_word_t   pending_words [$];
	update_report_t expected_reports [$];
	logic [KEY_W-1:0] seen_keys [$];

	sketch_word_t current_word;
	int unsigned  send_wait = 0;
	int unsigned  recv_wait = 0;
	logic         send_calm = 1'b0;
	logic         recv_calm = 1'b0;
	logic         hold_request = 1'b0;
	logic         hold_done = 1'b0;
	int unsigned  hold_left = 0;
	int unsigned  mismatches = 0;
	int unsigned  results_seen = 0;
	int unsigned  cycle_count = 0;

	function automatic logic [6:0] trailing_zeros(input logic [63:0] v);
		for (int i = 0; i < 64; i++) begin
			if (v[i]) return 7'(i);
		end
		return 7'd64;
	endfunction

	function automatic logic [KEY_W-1:0] hash_key(input logic [HASH_W-1:0] h);
		logic [63:0] pmask;
		pmask = (64'd1 << cur_sparse) - 64'd1;
		return KEY_W'(h & pmask);
	endfunction

	function automatic logic [VAL_W-1:0] hash_run(input logic [HASH_W-1:0] h);
		logic [63:0] pmask, lowmask, qmask, ntr, enc, nr;
		pmask   = (64'd1 << cur_sparse) - 64'd1;
		lowmask = (64'd1 << cur_precision) - 64'd1;
		qmask   = (64'd1 << cur_run_bits) - 64'd1;
		if ((h & (pmask ^ lowmask)) == 64'd0) begin
			// pack run above the key with the sign bit set, read back sign-extended
			ntr = 64'(trailing_zeros(h >> cur_precision)) + 64'd1;
			enc = ((h & pmask) | (ntr << cur_sparse) | (64'd1 << ENC_SIGN_BIT)) & 64'hFFFF_FFFF;
			enc |= 64'hFFFF_FFFF_0000_0000;
			nr = (enc >> cur_sparse) & qmask & 64'hFF;
		end else begin
			enc = h & 64'h7FFF_FFFF;
			nr = 64'(trailing_zeros(enc >> cur_precision)) + 64'd1;
		end
		return (nr > 64'(VAL_MAX)) ? VAL_MAX : VAL_W'(nr);
	endfunction

	function automatic update_report_t apply_update(input sketch_word_t w);
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		update_report_t r;
		if (w.operation == OP_MERGE) begin
			k = w.key;
			v = w.value;
		end else begin
			k = hash_key(w.hash);
			v = hash_run(w.hash);
		end
		r.updated = 1'b0;
		r.status = 1'b0;
		if (sparse_table.exists(k)) begin
			if (v > sparse_table[k]) begin
				sparse_table[k] = v;
				r.updated = 1'b1;
			end
		end else if (sparse_table.num() >= TABLE_SLOTS) begin
			r.status = 1'b1;
		end else begin
			sparse_table[k] = v;
			r.updated = 1'b1;
		end
		r.entry_count = CNT_W'(sparse_table.num());
		return r;
	endfunction

	function automatic int unsigned draw_gap(input logic calm);
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic sketch_word_t make_add(input logic [HASH_W-1:0] h);
		sketch_word_t w;
		w.operation = OP_ADD;
		w.hash = h;
		w.key = KEY_W'($urandom);
		w.value = VAL_W'($urandom);
		return w;
	endfunction

	function automatic sketch_word_t make_merge(input logic [KEY_W-1:0] k,
		input logic [VAL_W-1:0] v);
		sketch_word_t w;
		w.operation = OP_MERGE;
		w.hash = {$urandom, $urandom};
		w.key = k;
		w.value = v;
		return w;
	endfunction

	function automatic sketch_word_t random_word();
		sketch_word_t w;
		logic [63:0] pmask, lowmask, span_mask;
		int unsigned span;
		w = make_merge(KEY_W'($urandom), VAL_W'($urandom));
		pmask = (64'd1 << cur_sparse) - 64'd1;
		lowmask = (64'd1 << cur_precision) - 64'd1;
		if ($urandom_range(0, 99) < 45) begin
			if (seen_keys.size() != 0 && $urandom_range(0, 9) < 4)
				w.key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
		end else begin
			w.operation = OP_ADD;
			// clear a run above p to get long trailing zero counts
			if ($urandom_range(0, 9) < 3) begin
				span = $urandom_range(0, 63);
				span_mask = ((64'd1 << span) - 64'd1) << cur_precision;
				w.hash &= ~span_mask;
			end
			if ($urandom_range(0, 9) < 3) w.hash &= ~(pmask ^ lowmask);
			if (seen_keys.size() != 0 && $urandom_range(0, 9) < 2)
				w.hash = (w.hash & ~pmask)
					| (64'(seen_keys[$urandom_range(0, seen_keys.size() - 1)]) & pmask);
		end
		return w;
	endfunction

	function automatic void queue_word(input sketch_word_t w);
		pending_words.push_back(w);
		seen_keys.push_back((w.operation == OP_MERGE) ? w.key : hash_key(w.hash));
	endfunction

	task automatic drain();
		while (pending_words.size() != 0 || item_bus.valid || expected_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_PRECISION:        cur_precision = value;
			REG_SPARSE_PRECISION: cur_sparse = value;
			REG_RUN_BITS:         cur_run_bits = value[Q_W-1:0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic set_config(input logic [P_W-1:0] p, input logic [P_W-1:0] sp,
		input logic [Q_W-1:0] q);
		drain();
		write_register(REG_PRECISION, p);
		write_register(REG_SPARSE_PRECISION, sp);
		write_register(REG_RUN_BITS, CFG_DATA_W'(q));
		@(negedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		logic next_valid;
		sketch_word_t nxt;
		if (arst_n) begin
			next_valid = item_bus.valid;
			if (item_bus.valid && item_bus.ready) begin
				expected_reports.push_back(apply_update(current_word));
				next_valid = 1'b0;
				send_wait = draw_gap(send_calm);
			end
			if (!next_valid && pending_words.size() != 0) begin
				if (send_wait != 0) begin
					send_wait--;
				end else begin
					nxt = pending_words.pop_front();
					current_word = nxt;
					item_bus.operation <= nxt.operation;
					item_bus.hash_value <= nxt.hash;
					item_bus.entry_key <= nxt.key;
					item_bus.entry_value <= nxt.value;
					next_valid = 1'b1;
				end
			end
			item_bus.valid <= next_valid;
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		update_report_t want;
		logic next_ready;
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				results_seen++;
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d unexpected: updated=%0b count=%0d status=%0b",
							results_seen, result_bus.updated, result_bus.entry_count,
							result_bus.status);
				end else begin
					want = expected_reports.pop_front();
					if (result_bus.updated !== want.updated
						|| result_bus.entry_count !== want.entry_count
						|| result_bus.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected updated=%0b count=%0d status=%0b, got updated=%0b count=%0d status=%0b",
								results_seen, want.updated, want.entry_count, want.status,
								result_bus.updated, result_bus.entry_count, result_bus.status);
					end
				end
				recv_wait = draw_gap(recv_calm);
			end
			next_ready = 1'b0;
			if (hold_left == 0) begin
				if (recv_wait != 0) recv_wait--;
				else next_ready = 1'b1;
			end
			result_bus.ready <= next_ready;
		end
	end

	// one long hold-off of the receiver so the block backs up into its input
	always @(posedge clk) begin
		if (hold_request && !hold_done) begin
			hold_left <= HOLD_OFF_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] fill_keys [$];
		logic picked [logic [KEY_W-1:0]];
		int unsigned fresh_needed;
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.operation = OP_ADD;
		item_bus.hash_value = '0;
		item_bus.entry_key = '0;
		item_bus.entry_value = '0;
		result_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_PRECISION;
		cfg_bus.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: corners of the encoding and of the max update
		queue_word(make_add(64'd0));
		queue_word(make_add('1));
		queue_word(make_add(64'h8000_0000_0000_0000));
		queue_word(make_merge('0, VAL_MAX));
		queue_word(make_merge('0, VAL_MAX));
		queue_word(make_merge('0, 6'd0));
		queue_word(make_merge('1, 6'd0));
		queue_word(make_merge(25'h155_5555, 6'd0));
		queue_word(make_add(64'h4000));
		queue_word(make_add(64'h200_0000));
		queue_word(make_add(64'h100_0000_0000));
		queue_word(make_merge(25'h0AA_AAAA, VAL_MAX));
		queue_word(make_add(64'hFFFF_FFFF_FE00_0000));
		repeat (150) queue_word(random_word());

		set_config(5'd4, 5'd16, 3'd1);
		repeat (120) queue_word(random_word());

		// p equal to p': every hash takes the wide encoding
		set_config(5'd16, 5'd16, 3'd6);
		recv_calm = 1'b1;
		repeat (100) queue_word(random_word());

		set_config(5'd9, 5'd20, 3'd3);
		send_calm = 1'b1;
		repeat (150) queue_word(random_word());
		hold_request = 1'b1;

		// registers out of range: saturated runs, wide keys, p above p', empty run mask
		set_config(5'd31, 5'd31, 3'd7);
		send_calm = 1'b0;
		recv_calm = 1'b0;
		repeat (60) queue_word(random_word());
		set_config(5'd20, 5'd18, 3'd0);
		repeat (60) queue_word(random_word());

		// fill the table to the last slot
		set_config(5'd0, 5'd25, 3'd5);
		fresh_needed = TABLE_SLOTS - sparse_table.num();
		repeat (fresh_needed) begin
			do k = KEY_W'($urandom); while (sparse_table.exists(k) || picked.exists(k));
			picked[k] = 1'b1;
			fill_keys.push_back(k);
			queue_word(make_merge(k, VAL_W'($urandom_range(0, 31))));
		end
		drain();

		// full table: new keys drop, known keys still update
		for (int i = 0; i < 24; i++) begin
			do k = KEY_W'($urandom); while (sparse_table.exists(k));
			case (i % 4)
				0: queue_word(make_merge(k, VAL_W'($urandom)));
				1: queue_word(make_add({$urandom, 7'($urandom), k}));
				2: queue_word(make_merge(fill_keys[$urandom_range(0, fill_keys.size() - 1)],
					VAL_MAX));
				default: queue_word(make_merge(
					fill_keys[$urandom_range(0, fill_keys.size() - 1)], 6'd0));
			endcase
		end
		drain();
		repeat (40) @(posedge clk);

		if (mismatches == 0 && expected_reports.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
